// ----- rtl/ptt_pkg.sv -----
// ---------------------------------------------------------------------------
// ptt_pkg: shared types and constants of the periodic task timer table
// Command codes, sequencer states and result limits.
// ---------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

    localparam int unsigned KIND_W   = 3;
    localparam int unsigned SLOT_W   = 3;
    localparam int unsigned ARG_W    = 16;
    localparam int unsigned FIELD_W  = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned MAX_FIRE = 8;
    localparam int unsigned FCNT_W   = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK     = 3'd0,
        KIND_ADD      = 3'd1,
        KIND_REMOVE   = 3'd2,
        KIND_DISPATCH = 3'd3,
        KIND_SET_TIME = 3'd4
    } kind_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_EVAL  = 5'b00100,
        ST_FLUSH = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/ptt_if.sv -----
// ---------------------------------------------------------------------------
// ptt_if: command and result channels
// Valid/ready channels carrying one command word and one result word.
// ---------------------------------------------------------------------------
`default_nettype none

interface ptt_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [15:0] first_delay;
    logic [15:0] period_ticks;
    logic [15:0] task_argument;
    logic [31:0] new_time;

    modport source (
        output valid, kind, slot, first_delay, period_ticks, task_argument, new_time,
        input  ready
    );
    modport sink (
        input  valid, kind, slot, first_delay, period_ticks, task_argument, new_time,
        output ready
    );
endinterface

interface ptt_res_if;
    logic        valid;
    logic        ready;
    logic        fire;
    logic [2:0]  fired_slot;
    logic [15:0] fired_argument;
    logic [31:0] time_now;
    logic        last;

    modport source (
        output valid, fire, fired_slot, fired_argument, time_now, last,
        input  ready
    );
    modport sink (
        input  valid, fire, fired_slot, fired_argument, time_now, last,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/ptt_slot_ram.sv -----
// ---------------------------------------------------------------------------
// ptt_slot_ram: slot record storage
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ptt_slot_ram #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned WIDTH = 48
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/ptt_count_unit.sv -----
// ---------------------------------------------------------------------------
// ptt_count_unit: shared countdown unit
// Decrement one countdown and reload it from the period on expiry.
// ---------------------------------------------------------------------------
`default_nettype none

module ptt_count_unit #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic [COUNT_WIDTH-1:0] count,
    input  wire logic [COUNT_WIDTH-1:0] period,
    output logic      [COUNT_WIDTH-1:0] count_next,
    output logic                        expire
);

    logic [COUNT_WIDTH-1:0] dec;

    always_comb
    begin
        dec = (count != '0) ? (count - COUNT_WIDTH'(1)) : '0;
        expire = (dec == '0);
        count_next = expire ? period : dec;
    end

endmodule

`default_nettype wire

// ----- rtl/periodic_task_timer_table.sv -----
// ---------------------------------------------------------------------------
// periodic_task_timer_table: table of periodic task slots with a ms counter
//
// cmd carries one command word per handshake (tick, add, remove, dispatch,
// set time); res returns result words, each tagged with last on the final
// word of a command. cmd.ready is high only while the sequencer is idle.
// Add, remove, set time and unknown kinds go to the response state for
// their single result word. Tick and dispatch walk the slot records one
// slot at a time (RAM read, then countdown/compare); dispatch returns up
// to 8 words, one per due slot, in slot order. The walk is set by the
// single read port of the slot RAM and the one shared countdown unit.
// Results sit in an output register: a stalled res.ready holds the word and
// pauses the walk at the next word to emit; a new command is still taken
// while the last word of the previous one waits.
// Reset frees all slots, clears due flags and zeroes the time counter; the
// slot RAM itself is not cleared, the occupied flags guard it.
// ---------------------------------------------------------------------------
`default_nettype none

module periodic_task_timer_table
    import ptt_pkg::*;
#(
    parameter int unsigned NUM_SLOTS   = 8,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ptt_cmd_if.sink   cmd,
    ptt_res_if.source res
);

    localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned REC_W = 2 * COUNT_WIDTH + ARG_W;

    state_t                 state_reg, state_next;
    kind_t                  kind_reg, kind_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [FCNT_W-1:0]      n_reg, n_next;
    logic [IDX_W-1:0]       pend_slot_reg, pend_slot_next;
    logic [ARG_W-1:0]       pend_arg_reg, pend_arg_next;
    logic [TIME_W-1:0]      time_reg, time_next;
    logic [NUM_SLOTS-1:0]   occupied_reg, occupied_next;
    logic [NUM_SLOTS-1:0]   due_reg, due_next;

    logic                   res_valid_reg, res_valid_next;
    logic                   res_fire_reg, res_fire_next;
    logic [SLOT_W-1:0]      res_slot_reg, res_slot_next;
    logic [ARG_W-1:0]       res_arg_reg, res_arg_next;
    logic                   res_last_reg, res_last_next;
    logic [TIME_W-1:0]      res_time_reg, res_time_next;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [REC_W-1:0]       wr_data;
    logic                   rd_en;
    logic [REC_W-1:0]       rd_data;

    logic [COUNT_WIDTH-1:0] rec_count;
    logic [COUNT_WIDTH-1:0] rec_period;
    logic [ARG_W-1:0]       rec_arg;
    logic [COUNT_WIDTH-1:0] count_upd;
    logic                   expire;

    logic                   cmd_fire;
    logic                   out_free;
    logic                   slot_ok;
    logic [IDX_W-1:0]       cmd_idx;
    logic                   at_end;
    logic                   hit;

    assign rec_count  = rd_data[REC_W-1 -: COUNT_WIDTH];
    assign rec_period = rd_data[ARG_W +: COUNT_WIDTH];
    assign rec_arg    = rd_data[ARG_W-1:0];

    ptt_slot_ram #(
        .DEPTH (NUM_SLOTS),
        .WIDTH (REC_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    ptt_count_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_count (
        .count      (rec_count),
        .period     (rec_period),
        .count_next (count_upd),
        .expire     (expire)
    );

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign out_free  = !res_valid_reg || res.ready;
    assign slot_ok   = ({4'b0, cmd.slot} < 7'(NUM_SLOTS));
    assign cmd_idx   = IDX_W'(cmd.slot);
    assign at_end    = (idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign hit       = occupied_reg[idx_reg] && due_reg[idx_reg];

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        pend_slot_next = pend_slot_reg;
        pend_arg_next  = pend_arg_reg;
        time_next      = time_reg;
        occupied_next  = occupied_reg;
        due_next       = due_reg;

        res_valid_next = res_valid_reg && !res.ready;
        res_fire_next  = res_fire_reg;
        res_slot_next  = res_slot_reg;
        res_arg_next   = res_arg_reg;
        res_last_next  = res_last_reg;
        res_time_next  = res_time_reg;

        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = {count_upd, rec_period, rec_arg};
        rd_en   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    kind_next  = kind_t'(cmd.kind);
                    idx_next   = '0;
                    n_next     = '0;
                    state_next = ST_RESP;
                    case (kind_t'(cmd.kind))
                        KIND_TICK:
                        begin
                            time_next  = time_reg + TIME_W'(1);
                            state_next = ST_READ;
                        end
                        KIND_ADD:
                        begin
                            if (slot_ok)
                            begin
                                occupied_next[cmd_idx] = 1'b1;
                                due_next[cmd_idx]      = 1'b0;
                                wr_en   = 1'b1;
                                wr_addr = cmd_idx;
                                wr_data = {COUNT_WIDTH'(cmd.first_delay),
                                           COUNT_WIDTH'(cmd.period_ticks),
                                           cmd.task_argument};
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (slot_ok)
                            begin
                                occupied_next[cmd_idx] = 1'b0;
                                due_next[cmd_idx]      = 1'b0;
                            end
                        end
                        KIND_DISPATCH:
                        begin
                            state_next = ST_READ;
                        end
                        KIND_SET_TIME:
                        begin
                            time_next = cmd.new_time;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_EVAL;
            end

            ST_EVAL:
            begin
                if (kind_reg == KIND_TICK)
                begin
                    if (occupied_reg[idx_reg])
                    begin
                        wr_en = 1'b1;
                        if (expire)
                        begin
                            due_next[idx_reg] = 1'b1;
                        end
                    end
                    if (at_end)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
                else if (!hit || n_reg == '0 || out_free)
                begin
                    if (hit)
                    begin
                        if (n_reg != '0)
                        begin
                            res_valid_next = 1'b1;
                            res_fire_next  = 1'b1;
                            res_slot_next  = SLOT_W'(pend_slot_reg);
                            res_arg_next   = pend_arg_reg;
                            res_last_next  = 1'b0;
                            res_time_next  = time_reg;
                        end
                        pend_slot_next    = idx_reg;
                        pend_arg_next     = rec_arg;
                        n_next            = n_reg + FCNT_W'(1);
                        due_next[idx_reg] = 1'b0;
                        if (rec_period == '0)
                        begin
                            occupied_next[idx_reg] = 1'b0;
                        end
                    end
                    if (hit && n_reg == FCNT_W'(MAX_FIRE - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else if (at_end)
                    begin
                        state_next = (hit || n_reg != '0) ? ST_FLUSH : ST_RESP;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_fire_next  = 1'b1;
                    res_slot_next  = SLOT_W'(pend_slot_reg);
                    res_arg_next   = pend_arg_reg;
                    res_last_next  = 1'b1;
                    res_time_next  = time_reg;
                    state_next     = ST_IDLE;
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_fire_next  = 1'b0;
                    res_slot_next  = '0;
                    res_arg_next   = '0;
                    res_last_next  = 1'b1;
                    res_time_next  = time_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_TICK;
            idx_reg       <= '0;
            n_reg         <= '0;
            time_reg      <= '0;
            occupied_reg  <= '0;
            due_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            time_reg      <= time_next;
            occupied_reg  <= occupied_next;
            due_reg       <= due_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        pend_arg_reg  <= pend_arg_next;
        res_fire_reg  <= res_fire_next;
        res_slot_reg  <= res_slot_next;
        res_arg_reg   <= res_arg_next;
        res_last_reg  <= res_last_next;
        res_time_reg  <= res_time_next;
    end

    assign res.valid          = res_valid_reg;
    assign res.fire           = res_fire_reg;
    assign res.fired_slot     = res_slot_reg;
    assign res.fired_argument = res_arg_reg;
    assign res.time_now       = res_time_reg;
    assign res.last           = res_last_reg;

    a_due_needs_occupied: assert property (
        @(posedge clk) disable iff (!rst_n)
        (due_reg & ~occupied_reg) == '0
    ) else $error("due flag set on a free slot");

    a_fire_count_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        n_reg <= FCNT_W'(MAX_FIRE)
    ) else $error("dispatch took more than the result limit");

    a_flush_has_pending: assert property (
        @(posedge clk) disable iff (!rst_n)
        state_reg == ST_FLUSH |-> n_reg != '0
    ) else $error("final dispatch word without a pending slot");

    a_nonlast_fires: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_last_reg |-> res_fire_reg
    ) else $error("non-final word that names no task");

    a_busy_no_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !cmd.ready
    ) else $error("command taken during a walk");

endmodule

`default_nettype wire

// ----- tb/ptt_result_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptt_result_checker: scoreboard for the periodic task timer table
// Watches the command and result channels, keeps its own copy of the slot
// table and time counter, predicts the result words of every accepted
// command and compares each accepted result word with the oldest one due.
// ---------------------------------------------------------------------------

module ptt_result_checker
    import ptt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ptt_cmd_if         cmd,
    ptt_res_if         res,
    output int unsigned errors,
    output int unsigned pending
);

    localparam int unsigned SLOTS      = 8;
    localparam int unsigned SHOW_LIMIT = 10;

    typedef struct packed {
        logic              fire;
        logic [SLOT_W-1:0] slot;
        logic [ARG_W-1:0]  argument;
        logic [TIME_W-1:0] time_now;
        logic              last;
    } result_word_t;

    logic [SLOTS-1:0]   slot_live;
    logic [SLOTS-1:0]   slot_due;
    logic [FIELD_W-1:0] count_left [SLOTS];
    logic [FIELD_W-1:0] period     [SLOTS];
    logic [ARG_W-1:0]   argument   [SLOTS];
    logic [TIME_W-1:0]  ms_count;

    result_word_t expected_words [$];
    int unsigned  fault_count;

    function automatic result_word_t word_of(input logic              fire,
                                             input logic [SLOT_W-1:0] slot,
                                             input logic [ARG_W-1:0]  arg,
                                             input logic              last);
        result_word_t w;
        w.fire     = fire;
        w.slot     = slot;
        w.argument = arg;
        w.time_now = ms_count;
        w.last     = last;
        return w;
    endfunction

    task automatic step_table(input logic [KIND_W-1:0]  kind,
                              input logic [SLOT_W-1:0]  slot,
                              input logic [FIELD_W-1:0] first_delay,
                              input logic [FIELD_W-1:0] period_ticks,
                              input logic [ARG_W-1:0]   task_argument,
                              input logic [TIME_W-1:0]  new_time);
        int unsigned  fired;
        result_word_t w;
        fired = 0;
        case (kind)
            KIND_TICK:
            begin
                ms_count = ms_count + 1'b1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_live[i])
                    begin
                        if (count_left[i] != '0)
                            count_left[i] = count_left[i] - 1'b1;
                        if (count_left[i] == '0)
                        begin
                            count_left[i] = period[i];
                            slot_due[i]   = 1'b1;
                        end
                    end
                end
            end
            KIND_ADD:
            begin
                slot_live[slot]  = 1'b1;
                slot_due[slot]   = 1'b0;
                count_left[slot] = first_delay;
                period[slot]     = period_ticks;
                argument[slot]   = task_argument;
            end
            KIND_REMOVE:
            begin
                slot_live[slot] = 1'b0;
                slot_due[slot]  = 1'b0;
            end
            KIND_DISPATCH:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_live[i] && slot_due[i] && fired < MAX_FIRE)
                    begin
                        expected_words.push_back(word_of(1'b1, SLOT_W'(i), argument[i], 1'b0));
                        fired++;
                        slot_due[i] = 1'b0;
                        if (period[i] == '0)
                            slot_live[i] = 1'b0;
                    end
                end
            end
            KIND_SET_TIME:
            begin
                ms_count = new_time;
            end
            default:
            begin
            end
        endcase
        if (fired == 0)
        begin
            expected_words.push_back(word_of(1'b0, '0, '0, 1'b1));
        end
        else
        begin
            w      = expected_words.pop_back();
            w.last = 1'b1;
            expected_words.push_back(w);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        result_word_t got;
        result_word_t want;
        if (!rst_n)
        begin
            slot_live   = '0;
            slot_due    = '0;
            ms_count    = '0;
            fault_count = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                count_left[i] = '0;
                period[i]     = '0;
                argument[i]   = '0;
            end
            expected_words.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                got.fire     = res.fire;
                got.slot     = res.fired_slot;
                got.argument = res.fired_argument;
                got.time_now = res.time_now;
                got.last     = res.last;
                if (expected_words.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= SHOW_LIMIT)
                        $display("%0t: unexpected fire=%0d slot=%0d arg=%h time=%h last=%0d",
                                 $realtime, got.fire, got.slot, got.argument, got.time_now,
                                 got.last);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                    begin
                        fault_count++;
                        if (fault_count <= SHOW_LIMIT)
                        begin
                            $display("%0t: expected fire=%0d slot=%0d arg=%h time=%h last=%0d",
                                     $realtime, want.fire, want.slot, want.argument,
                                     want.time_now, want.last);
                            $display("%0t: got      fire=%0d slot=%0d arg=%h time=%h last=%0d",
                                     $realtime, got.fire, got.slot, got.argument,
                                     got.time_now, got.last);
                        end
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                step_table(cmd.kind, cmd.slot, cmd.first_delay, cmd.period_ticks,
                           cmd.task_argument, cmd.new_time);
            errors  <= fault_count;
            pending <= expected_words.size();
        end
    end

endmodule

// ----- tb/tb_periodic_task_timer_table.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_periodic_task_timer_table: testbench top of the periodic task timer table
// Drives command words (directed corner cases, then weighted random traffic
// with idle gaps, a long result hold-off and a drain pause), drives result
// ready, and reports the verdict from the scoreboard's fault and backlog.
// ---------------------------------------------------------------------------

module tb_periodic_task_timer_table;
    import ptt_pkg::*;

    localparam int unsigned RANDOM_WORDS = 206;
    localparam int unsigned KIND_TOP     = 7;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned QUIET_LIMIT  = 3000;
    localparam int unsigned DRAIN_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n;
    logic calm;
    logic hold_req;

    int unsigned fault_total;
    int unsigned words_waiting;
    int unsigned quiet_cycles = 0;

    ptt_cmd_if cmd_ch ();
    ptt_res_if res_ch ();

    periodic_task_timer_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    ptt_result_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .res     (res_ch),
        .errors  (fault_total),
        .pending (words_waiting)
    );

    always #5 clk = ~clk;

    initial
    begin : result_sink
        int unsigned hold_left;
        logic        hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req && !hold_done)
            begin
                res_ch.ready <= 1'b0;
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else
            begin
                res_ch.ready <= calm || ($urandom_range(99) >= 8);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [KIND_W-1:0]  kind,
                             input logic [SLOT_W-1:0]  slot,
                             input logic [FIELD_W-1:0] first_delay,
                             input logic [FIELD_W-1:0] period_ticks,
                             input logic [ARG_W-1:0]   task_argument,
                             input logic [TIME_W-1:0]  new_time);
        while (!calm && $urandom_range(99) < 8)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.kind          <= kind;
        cmd_ch.slot          <= slot;
        cmd_ch.first_delay   <= first_delay;
        cmd_ch.period_ticks  <= period_ticks;
        cmd_ch.task_argument <= task_argument;
        cmd_ch.new_time      <= new_time;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] first_delay;
        logic [FIELD_W-1:0] period_ticks;
        logic [ARG_W-1:0]   task_argument;
        logic [TIME_W-1:0]  new_time;
        int unsigned        pick;

        calm                 = 1'b0;
        hold_req             = 1'b0;
        rst_n                = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.kind          = KIND_TICK;
        cmd_ch.slot          = '0;
        cmd_ch.first_delay   = '0;
        cmd_ch.period_ticks  = '0;
        cmd_ch.task_argument = '0;
        cmd_ch.new_time      = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(KIND_DISPATCH, '0, '0, '0, '0, '0);
        send_word(KIND_TICK, '0, '0, '0, '0, '0);
        send_word(KIND_SET_TIME, '0, '0, '0, '0, 32'hFFFF_FFFF);
        send_word(KIND_TICK, '0, '0, '0, '0, '0);
        send_word(KIND_ADD, 3'd0, 16'h0000, 16'h0000, 16'hFFFF, '0);
        send_word(KIND_ADD, 3'd7, 16'h0001, 16'hFFFF, 16'h0000, '0);
        send_word(KIND_ADD, 3'd6, 16'hFFFF, 16'h0001, 16'hA5A5, '0);
        for (int s = 1; s <= 6; s++)
            send_word(KIND_ADD, SLOT_W'(s), 16'h0001, 16'h0002, ARG_W'(s * 16'h1111), '0);
        send_word(KIND_TICK, '0, '0, '0, '0, '0);
        send_word(KIND_DISPATCH, '0, '0, '0, '0, '0);
        send_word(KIND_REMOVE, 3'd0, '0, '0, '0, '0);
        send_word(KIND_REMOVE, 3'd3, '0, '0, '0, '0);
        for (int k = KIND_SET_TIME + 1; k <= KIND_TOP; k++)
            send_word(KIND_W'(k), '1, '1, '1, '1, '1);
        send_word(KIND_TICK, '0, '0, '0, '0, '0);
        send_word(KIND_TICK, '0, '0, '0, '0, '0);
        send_word(KIND_DISPATCH, '0, '0, '0, '0, '0);
        send_word(KIND_SET_TIME, '0, '0, '0, '0, '0);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == 50)
                calm <= 1'b1;
            if (i == 100)
                calm <= 1'b0;
            if (i == 120)
                hold_req <= 1'b1;
            if (i == 170)
            begin
                cmd_ch.valid <= 1'b0;
                @(posedge clk);
                while (words_waiting != 0)
                    @(posedge clk);
            end
            pick          = $urandom_range(99);
            slot          = SLOT_W'($urandom);
            first_delay   = FIELD_W'($urandom);
            period_ticks  = FIELD_W'($urandom);
            task_argument = ARG_W'($urandom);
            new_time      = $urandom;
            if (pick < 40)
            begin
                kind = KIND_TICK;
            end
            else if (pick < 58)
            begin
                kind = KIND_ADD;
                if ($urandom_range(9) < 8)
                begin
                    first_delay  = FIELD_W'($urandom_range(4));
                    period_ticks = FIELD_W'($urandom_range(5));
                end
            end
            else if (pick < 66)
            begin
                kind = KIND_REMOVE;
            end
            else if (pick < 90)
            begin
                kind = KIND_DISPATCH;
            end
            else if (pick < 96)
            begin
                kind = KIND_SET_TIME;
                if ($urandom_range(1) == 1)
                    new_time = 32'hFFFF_FFFF - $urandom_range(3);
            end
            else
            begin
                kind = KIND_W'($urandom_range(KIND_TOP, KIND_SET_TIME + 1));
            end
            send_word(kind, slot, first_delay, period_ticks, task_argument, new_time);
        end
        cmd_ch.valid <= 1'b0;
        @(posedge clk);

        while (words_waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_total == 0 && words_waiting == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- periodic_task_timer_table.f -----
rtl/ptt_pkg.sv
rtl/ptt_if.sv
rtl/ptt_slot_ram.sv
rtl/ptt_count_unit.sv
rtl/periodic_task_timer_table.sv
tb/ptt_result_checker.sv
tb/tb_periodic_task_timer_table.sv
